FILE: src/lfu_pr_pkg.sv
// ----------------------------------------------------------------------------
// LFU page replacement package
// Shared constants, register map and sequencer state type for the
// least-frequently-used page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pr_pkg;

    // Fixed field widths of the result and input channels.
    localparam int PAGE_BITS     = 16;
    localparam int FRAME_INDEX_W = 3;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_FRAMES = 8;
    localparam int DEF_COUNT_BITS = 16;
    localparam int DEF_TIME_BITS  = 32;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CFG_W      = 4;

    // Word index of each register (byte address is four times this).
    localparam logic [APB_ADDR_W-3:0] REG_FRAMES_IN_USE = '0;

    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

endpackage : lfu_pr_pkg

`default_nettype wire

FILE: src/lfu_page_replacement.sv
// ----------------------------------------------------------------------------
// LFU page replacement
// Least-frequently-used page replacement with a first-in tie break over a
// small set of page frames, scanned one frame per cycle.
// ----------------------------------------------------------------------------
//
// Usage: each transfer on the input channel (in_valid, in_stall,
// page_number) is one page reference. For each reference the block returns
// one transfer on the result channel (out_valid, out_stall, hit,
// frame_index, evicted_valid, evicted_page).
// The frame table is held in a small memory that one comparator walks,
// one frame per cycle. A reference is accepted in the idle state, the scan
// reads each of the n active frames and judges each read against the
// running results, and the write step updates the frame and loads the
// result register; only then is a new reference accepted. in_stall is high
// while a reference is being processed.
// The result sits in an output register, so a new reference is accepted
// while an earlier result still waits; if the receiver keeps out_stall high,
// the finished reference waits in its write step until the register frees.
// Reset empties all frames, sets the reference time to zero and sets
// frames_in_use to eight. The APB port holds frames_in_use at byte address
// zero; the user must write it only while the block is idle, as the block
// itself does not enforce it.
`default_nettype none

module lfu_page_replacement
    import lfu_pr_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int TIME_BITS  = DEF_TIME_BITS
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    // Configuration port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0]    pwdata,
    output logic      [APB_DATA_W-1:0]    prdata,
    output logic                          pready,

    // Reference channel
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [PAGE_BITS-1:0]     page_number,

    // Result channel
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          hit,
    output logic      [FRAME_INDEX_W-1:0] frame_index,
    output logic                          evicted_valid,
    output logic      [PAGE_BITS-1:0]     evicted_page
);

    // Frame index width and the width of a count of frames (0..MAX_FRAMES).
    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NUM_W = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W = (NUM_W > CFG_W) ? NUM_W : CFG_W;

    typedef struct packed {
        logic [PAGE_BITS-1:0]  page;
        logic [COUNT_BITS-1:0] count;
        logic [TIME_BITS-1:0]  load_time;
    } entry_t;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] frames_in_use_reg;
    logic             cfg_sel;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[APB_ADDR_W-1:2] == REG_FRAMES_IN_USE);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
    assign prdata  = cfg_sel ? APB_DATA_W'(frames_in_use_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= FRAMES_IN_USE_RESET;
        end
        else if (cfg_wr)
        begin
            frames_in_use_reg <= pwdata[CFG_W-1:0];
        end
    end

    // A setting of zero acts as one frame; anything above the table size
    // is clamped to the table size.
    logic [CMP_W-1:0] cfg_ext;
    logic [NUM_W-1:0] n_active;

    assign cfg_ext = CMP_W'(frames_in_use_reg);

    always_comb
    begin
        priority if (frames_in_use_reg == '0)
        begin
            n_active = NUM_W'(1);
        end
        else if (cfg_ext > CMP_W'(MAX_FRAMES))
        begin
            n_active = NUM_W'(MAX_FRAMES);
        end
        else
        begin
            n_active = NUM_W'(cfg_ext);
        end
    end

    // ------------------------------------------------------------------
    // Frame table memory: one read port used by the scan, one write port
    // used by the update step. Valid bits live in flip-flops so that reset
    // empties the table at once.
    // ------------------------------------------------------------------
    entry_t           frame_mem [MAX_FRAMES];
    entry_t           rd_data_reg;
    logic [IDX_W-1:0] mem_raddr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= frame_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Sequencer and scan registers
    // ------------------------------------------------------------------
    state_t                 state_reg,       state_next;
    logic [NUM_W-1:0]       scan_idx_reg,    scan_idx_next;
    logic                   rd_pend_reg,     rd_pend_next;
    logic [IDX_W-1:0]       rd_idx_reg,      rd_idx_next;
    logic [PAGE_BITS-1:0]   page_reg,        page_next;
    logic                   hit_found_reg,   hit_found_next;
    logic [IDX_W-1:0]       hit_idx_reg,     hit_idx_next;
    entry_t                 hit_entry_reg,   hit_entry_next;
    logic                   free_found_reg,  free_found_next;
    logic [IDX_W-1:0]       free_idx_reg,    free_idx_next;
    logic                   vic_found_reg,   vic_found_next;
    logic [IDX_W-1:0]       vic_idx_reg,     vic_idx_next;
    entry_t                 vic_entry_reg,   vic_entry_next;
    logic [MAX_FRAMES-1:0]  frame_valid_reg, frame_valid_next;
    logic [TIME_BITS-1:0]   ref_time_reg,    ref_time_next;

    logic                   out_valid_reg,   out_valid_next;
    logic                   hit_reg,         hit_next;
    logic [FRAME_INDEX_W-1:0] frame_index_reg, frame_index_next;
    logic                   ev_valid_reg,    ev_valid_next;
    logic [PAGE_BITS-1:0]   ev_page_reg,     ev_page_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            scan_idx_reg    <= '0;
            rd_pend_reg     <= 1'b0;
            hit_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
            vic_found_reg   <= 1'b0;
            frame_valid_reg <= '0;
            ref_time_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_idx_reg    <= scan_idx_next;
            rd_pend_reg     <= rd_pend_next;
            hit_found_reg   <= hit_found_next;
            free_found_reg  <= free_found_next;
            vic_found_reg   <= vic_found_next;
            frame_valid_reg <= frame_valid_next;
            ref_time_reg    <= ref_time_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        rd_idx_reg      <= rd_idx_next;
        page_reg        <= page_next;
        hit_idx_reg     <= hit_idx_next;
        hit_entry_reg   <= hit_entry_next;
        free_idx_reg    <= free_idx_next;
        vic_idx_reg     <= vic_idx_next;
        vic_entry_reg   <= vic_entry_next;
        hit_reg         <= hit_next;
        frame_index_reg <= frame_index_next;
        ev_valid_reg    <= ev_valid_next;
        ev_page_reg     <= ev_page_next;
    end

    always_comb
    begin
        logic             issue;
        logic             rd_valid;
        logic             better;
        logic             evict;
        logic [IDX_W-1:0] slot;

        // Hold everything by default.
        state_next       = state_reg;
        scan_idx_next    = scan_idx_reg;
        rd_pend_next     = 1'b0;
        rd_idx_next      = rd_idx_reg;
        page_next        = page_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        hit_entry_next   = hit_entry_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        vic_found_next   = vic_found_reg;
        vic_idx_next     = vic_idx_reg;
        vic_entry_next   = vic_entry_reg;
        frame_valid_next = frame_valid_reg;
        ref_time_next    = ref_time_reg;
        out_valid_next   = out_valid_reg;
        hit_next         = hit_reg;
        frame_index_next = frame_index_reg;
        ev_valid_next    = ev_valid_reg;
        ev_page_next     = ev_page_reg;

        mem_raddr = scan_idx_reg[IDX_W-1:0];
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        in_stall  = 1'b1;

        issue    = 1'b0;
        rd_valid = 1'b0;
        better   = 1'b0;
        evict    = 1'b0;
        slot     = '0;

        // The receiver taking the current result frees the output register.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    page_next       = page_number;
                    scan_idx_next   = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    vic_found_next  = 1'b0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue one frame read per cycle; the frame read in the
                // previous cycle is judged against the running results.
                issue = (scan_idx_reg < n_active);
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + NUM_W'(1);
                    rd_pend_next  = 1'b1;
                    rd_idx_next   = scan_idx_reg[IDX_W-1:0];
                end
                else
                begin
                    state_next = ST_WRITE;
                end

                if (rd_pend_reg)
                begin
                    rd_valid = frame_valid_reg[rd_idx_reg];
                    if (rd_valid)
                    begin
                        if (!hit_found_reg && (rd_data_reg.page == page_reg))
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = rd_idx_reg;
                            hit_entry_next = rd_data_reg;
                        end
                        // Smallest count wins; equal counts go to the
                        // earlier load time, then to the lower frame.
                        better = !vic_found_reg
                              || (rd_data_reg.count < vic_entry_reg.count)
                              || ((rd_data_reg.count == vic_entry_reg.count)
                                  && (rd_data_reg.load_time
                                      < vic_entry_reg.load_time));
                        if (better)
                        begin
                            vic_found_next = 1'b1;
                            vic_idx_next   = rd_idx_reg;
                            vic_entry_next = rd_data_reg;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                end
            end

            ST_WRITE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    evict = !hit_found_reg && !free_found_reg;
                    priority if (hit_found_reg)
                    begin
                        slot = hit_idx_reg;
                    end
                    else if (free_found_reg)
                    begin
                        slot = free_idx_reg;
                    end
                    else
                    begin
                        slot = vic_idx_reg;
                    end

                    mem_we    = 1'b1;
                    mem_waddr = slot;
                    if (hit_found_reg)
                    begin
                        mem_wdata = hit_entry_reg;
                        if (hit_entry_reg.count != '1)
                        begin
                            mem_wdata.count = hit_entry_reg.count + COUNT_BITS'(1);
                        end
                    end
                    else
                    begin
                        mem_wdata.page      = page_reg;
                        mem_wdata.count     = COUNT_BITS'(1);
                        mem_wdata.load_time = ref_time_reg;
                    end

                    frame_valid_next[slot] = 1'b1;
                    if (ref_time_reg != '1)
                    begin
                        ref_time_next = ref_time_reg + TIME_BITS'(1);
                    end

                    out_valid_next   = 1'b1;
                    hit_next         = hit_found_reg;
                    frame_index_next = FRAME_INDEX_W'(slot);
                    ev_valid_next    = evict;
                    ev_page_next     = evict ? vic_entry_reg.page : '0;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;

endmodule : lfu_page_replacement

`default_nettype wire

FILE: src/lfu_pr_checker.sv
// ----------------------------------------------------------------------------
// LFU page replacement checker
// Port-level assertions for the LFU page replacement block, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_pr_checker
    import lfu_pr_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_stall,
    input wire logic                     out_valid,
    input wire logic                     out_stall,
    input wire logic                     hit,
    input wire logic [FRAME_INDEX_W-1:0] frame_index,
    input wire logic                     evicted_valid,
    input wire logic [PAGE_BITS-1:0]     evicted_page
);

    // A stalled result keeps its valid and its fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable(hit) && $stable(frame_index)
            && $stable(evicted_valid) && $stable(evicted_page))
        else $error("stalled result changed");

    // A hit never evicts.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !evicted_valid)
        else $error("hit reported an eviction");

    // Without an eviction the evicted page reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted_valid |-> evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    // The block scans the frame table after each accepted reference.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("reference accepted during a scan");

endmodule : lfu_pr_checker

bind lfu_page_replacement lfu_pr_checker u_lfu_pr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page)
);

`default_nettype wire
